>>> rtl/battery_average_charge_controller_macros.svh
`ifndef BATTERY_AVERAGE_CHARGE_CONTROLLER_MACROS_SVH
`define BATTERY_AVERAGE_CHARGE_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define BACC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bacc_pkg.sv
package bacc_pkg;

  localparam int SAMPLE_BITS = 12;

  typedef logic [SAMPLE_BITS-1:0] level_t;

  localparam level_t LEVEL_MAX = '1;

  localparam logic [2:0] CMD_NONE            = 3'd0;
  localparam logic [2:0] CMD_TOGGLE_CYCLE    = 3'd1;
  localparam logic [2:0] CMD_START_CHARGE    = 3'd2;
  localparam logic [2:0] CMD_START_DISCHARGE = 3'd3;
  localparam logic [2:0] CMD_STOP            = 3'd4;

  localparam logic [2:0] REG_UPPER      = 3'd0;
  localparam logic [2:0] REG_LOWER      = 3'd1;
  localparam logic [2:0] REG_CHARGED    = 3'd2;
  localparam logic [2:0] REG_DISCHARGED = 3'd3;
  localparam logic [2:0] REG_DEPLETED   = 3'd4;
  localparam logic [2:0] REG_ABSENT     = 3'd5;
  localparam logic [2:0] REG_RATE       = 3'd6;

  localparam logic [5:0] PERIOD_TEN   = 6'd10;
  localparam logic [5:0] PERIOD_SIXTY = 6'd60;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_CYCLE     = 2'd1,
    MODE_DISCHARGE = 2'd2,
    MODE_CHARGE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STEP_DISCHARGE = 2'd0,
    STEP_CHARGE    = 2'd1,
    STEP_FINAL     = 2'd2
  } step_t;

  typedef enum logic [1:0] {
    RATE_EVERY = 2'd0,
    RATE_TEN   = 2'd1,
    RATE_SIXTY = 2'd2,
    RATE_NEVER = 2'd3
  } rate_t;

  typedef struct packed {
    level_t upper;
    level_t lower;
    level_t charged;
    level_t discharged;
    level_t depleted;
    level_t absent;
    rate_t  rate;
  } cfg_t;

  // packed so that charge sits in bit 0, as on the output stream
  typedef struct packed {
    step_t  cycle_step;
    mode_t  mode;
    logic   shutdown;
    logic   report;
    logic   level_valid;
    level_t level;
    logic   discharge;
    logic   charge;
  } res_t;

endpackage

>>> rtl/battery_average_charge_controller.sv
// each result passes through the input register and then the result register
// throughput: one item per cycle unless m_tready stalls, set by the window and sequencer update
// while a result waits on m_tready an empty input register still takes one item
// rst (synchronous, active high) clears the window, sequencer, counters and both
// stream stages, and loads every configuration register with its default
module battery_average_charge_controller #(
  parameter int WINDOW_DEPTH  = 16,
  parameter int AVERAGE_SHIFT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cmd[2:0], adc_sample[14:3], external_power_absent[15]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // charge_enable, discharge_enable, battery_level[13:2],
                                 // level_valid, report_event, shutdown_request,
                                 // mode_now[18:17], cycle_step_now[20:19], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bacc_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic [2:0] in_cmd;
  level_t     in_sample;
  logic       in_absent;
  logic       advance;
  logic       full_next;
  level_t     avg_next;
  res_t       res;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper      <= 12'd3437;
      cfg.lower      <= 12'd3345;
      cfg.charged    <= 12'd3757;
      cfg.discharged <= 12'd3070;
      cfg.depleted   <= 12'd2978;
      cfg.absent     <= 12'd100;
      cfg.rate       <= RATE_SIXTY;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_UPPER:      cfg.upper      <= pwdata[11:0];
        REG_LOWER:      cfg.lower      <= pwdata[11:0];
        REG_CHARGED:    cfg.charged    <= pwdata[11:0];
        REG_DISCHARGED: cfg.discharged <= pwdata[11:0];
        REG_DEPLETED:   cfg.depleted   <= pwdata[11:0];
        REG_ABSENT:     cfg.absent     <= pwdata[11:0];
        REG_RATE:       cfg.rate       <= rate_t'(pwdata[1:0]);
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_UPPER:      prdata = {20'd0, cfg.upper};
      REG_LOWER:      prdata = {20'd0, cfg.lower};
      REG_CHARGED:    prdata = {20'd0, cfg.charged};
      REG_DISCHARGED: prdata = {20'd0, cfg.discharged};
      REG_DEPLETED:   prdata = {20'd0, cfg.depleted};
      REG_ABSENT:     prdata = {20'd0, cfg.absent};
      REG_RATE:       prdata = {30'd0, cfg.rate};
      default:        prdata = '0;
    endcase
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd    <= s_tdata[2:0];
      in_sample <= s_tdata[14:3];
      in_absent <= s_tdata[15];
    end
  end

  bacc_window #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .AVERAGE_SHIFT (AVERAGE_SHIFT)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .sample       (in_sample),
    .absent_level (cfg.absent),
    .full_next    (full_next),
    .avg_next     (avg_next)
  );

  bacc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .cmd        (in_cmd),
    .on_battery (in_absent),
    .full_next  (full_next),
    .avg_next   (avg_next),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {3'd0, res};
    end
  end

endmodule

>>> rtl/bacc_window.sv
module bacc_window #(
  parameter int WINDOW_DEPTH  = 16,
  parameter int AVERAGE_SHIFT = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  bacc_pkg::level_t sample,
  input  bacc_pkg::level_t absent_level,
  output logic            full_next,
  output bacc_pkg::level_t avg_next
);
  import bacc_pkg::*;

  localparam int SLOT_BITS  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int TOTAL_BITS = SAMPLE_BITS + SLOT_BITS;
  localparam logic [SLOT_BITS-1:0]  LAST_SLOT = SLOT_BITS'(WINDOW_DEPTH - 1);
  localparam logic [TOTAL_BITS-1:0] SAT_LIMIT = TOTAL_BITS'(LEVEL_MAX);

  level_t                  window [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] vld;
  logic [TOTAL_BITS-1:0]   total;
  logic [SLOT_BITS-1:0]    slot;
  logic                    full;

  logic                    absent;
  level_t                  old;
  logic [TOTAL_BITS-1:0]   total_next;
  logic [TOTAL_BITS-1:0]   shifted;

  assign absent     = (sample <= absent_level);
  assign old        = vld[slot] ? window[slot] : '0;
  assign total_next = total - TOTAL_BITS'(old) + TOTAL_BITS'(sample);
  assign shifted    = total_next >> AVERAGE_SHIFT;
  assign full_next  = !absent && (full || (slot == LAST_SLOT));
  assign avg_next   = (shifted > SAT_LIMIT) ? LEVEL_MAX : shifted[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      total <= '0;
      slot  <= '0;
      full  <= 1'b0;
    end else if (step) begin
      if (absent) begin
        vld   <= '0;
        total <= '0;
        slot  <= '0;
        full  <= 1'b0;
      end else begin
        vld[slot] <= 1'b1;
        total     <= total_next;
        slot      <= (slot == LAST_SLOT) ? '0 : slot + SLOT_BITS'(1);
        full      <= full_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !absent) begin
      window[slot] <= sample;
    end
  end

endmodule

>>> rtl/bacc_seq.sv
module bacc_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [2:0]       cmd,
  input  logic             on_battery,
  input  logic             full_next,
  input  bacc_pkg::level_t avg_next,
  input  bacc_pkg::cfg_t   cfg,
  output bacc_pkg::res_t   res
);
  import bacc_pkg::*;

  mode_t      mode, mode_next;
  step_t      cstep, cstep_next;
  logic       chg, chg_next;
  logic       dis, dis_next;
  logic [5:0] cnt, cnt_next;
  level_t     hold, hold_next;
  logic       shut;
  logic       rep;

  always_comb begin
    mode_next  = mode;
    cstep_next = cstep;
    chg_next   = chg;
    dis_next   = dis;
    hold_next  = hold;
    cnt_next   = cnt;
    shut       = 1'b0;
    rep        = 1'b0;

    case (cmd)
      CMD_TOGGLE_CYCLE: begin
        if (mode == MODE_CYCLE) begin
          mode_next = MODE_IDLE;
        end else begin
          mode_next  = MODE_CYCLE;
          cstep_next = STEP_DISCHARGE;
        end
      end
      CMD_START_CHARGE:    mode_next = MODE_CHARGE;
      CMD_START_DISCHARGE: mode_next = MODE_DISCHARGE;
      CMD_STOP:            mode_next = MODE_IDLE;
      default:             ;
    endcase

    if (full_next) begin
      hold_next = avg_next;
      if (on_battery) begin
        mode_next = MODE_IDLE;
        chg_next  = 1'b0;
        dis_next  = 1'b0;
        shut      = (avg_next <= cfg.depleted);
      end else begin
        case (mode_next)
          MODE_IDLE: begin
            if (avg_next <= cfg.lower || avg_next <= cfg.discharged) begin
              chg_next = 1'b1;
              dis_next = 1'b0;
            end
            if (avg_next >= cfg.upper || avg_next >= cfg.charged) begin
              chg_next = 1'b0;
              dis_next = 1'b0;
            end
          end
          MODE_CYCLE: begin
            if (cstep_next == STEP_DISCHARGE) begin
              chg_next = 1'b0;
              dis_next = 1'b1;
              if (avg_next <= cfg.discharged) begin
                cstep_next = STEP_CHARGE;
                chg_next   = 1'b1;
                dis_next   = 1'b0;
              end
            end
            if (cstep_next == STEP_CHARGE && avg_next >= cfg.charged) begin
              cstep_next = STEP_FINAL;
              chg_next   = 1'b0;
              dis_next   = 1'b1;
            end
            if (cstep_next == STEP_FINAL && avg_next <= cfg.upper) begin
              mode_next = MODE_IDLE;
              chg_next  = 1'b0;
              dis_next  = 1'b0;
            end
          end
          MODE_DISCHARGE: begin
            chg_next = 1'b0;
            dis_next = 1'b1;
            if (avg_next <= cfg.discharged) begin
              mode_next = MODE_IDLE;
              dis_next  = 1'b0;
            end
          end
          default: begin
            chg_next = 1'b1;
            dis_next = 1'b0;
            if (avg_next >= cfg.charged) begin
              mode_next = MODE_IDLE;
              chg_next  = 1'b0;
            end
          end
        endcase
      end
    end else begin
      mode_next = MODE_IDLE;
      chg_next  = 1'b0;
      dis_next  = 1'b0;
    end

    case (cfg.rate)
      RATE_TEN, RATE_SIXTY: begin
        cnt_next = cnt + 6'd1;
        if (cnt_next == ((cfg.rate == RATE_TEN) ? PERIOD_TEN : PERIOD_SIXTY)) begin
          cnt_next = '0;
          rep      = full_next;
        end
      end
      RATE_EVERY: begin
        cnt_next = '0;
        rep      = full_next;
      end
      default: cnt_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      cstep <= STEP_DISCHARGE;
      chg   <= 1'b0;
      dis   <= 1'b0;
      cnt   <= '0;
      hold  <= '0;
    end else if (step) begin
      mode  <= mode_next;
      cstep <= cstep_next;
      chg   <= chg_next;
      dis   <= dis_next;
      cnt   <= cnt_next;
      hold  <= hold_next;
    end
  end

  always_comb begin
    res.cycle_step  = cstep_next;
    res.mode        = mode_next;
    res.shutdown    = shut;
    res.report      = rep;
    res.level_valid = full_next;
    res.level       = hold_next;
    res.discharge   = dis_next;
    res.charge      = chg_next;
  end

endmodule

>>> rtl/bacc_checker.sv
`include "battery_average_charge_controller_macros.svh"

module bacc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  `BACC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `BACC_ASSERT_NOW(a_pins_exclusive, m_tvalid, !(m_tdata[0] && m_tdata[1]), "charge and discharge both enabled")
  `BACC_ASSERT_NOW(a_shutdown_idle, m_tvalid && m_tdata[16], m_tdata[1:0] == 2'b00 && m_tdata[18:17] == 2'b00, "shutdown with pins on or mode not idle")
  `BACC_ASSERT_NOW(a_invalid_idle, m_tvalid && !m_tdata[14], m_tdata[1:0] == 2'b00 && m_tdata[18:17] == 2'b00 && !m_tdata[15] && !m_tdata[16], "activity before window full")

endmodule

bind battery_average_charge_controller bacc_checker u_bacc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
